>>> hw/rtl/cacnt_pkg.sv
// ----------------------------------------------------------------------------
// cacnt_pkg
// Shared types and constants of the call-arc count table.
// ----------------------------------------------------------------------------
package cacnt_pkg;

	localparam int BUCKETS     = 4096;
	localparam int ARC_ENTRIES = 1024;

	localparam int BUCKET_W = $clog2(BUCKETS);
	localparam int IDX_W    = $clog2(ARC_ENTRIES);
	localparam int LA_W     = $clog2(ARC_ENTRIES + 1);
	localparam int RIDX_W   = 12;
	localparam int CNT_W    = 24;
	localparam int PC_W     = 32;
	localparam int ST_W     = 3;
	localparam int OUTI_W   = 11;
	localparam int CFG_W    = 32;
	localparam int CFGI_W   = 2;
	localparam int WSIZE_W  = 15;
	localparam int Q_DEPTH  = 2;
	localparam int Q_PTR_W  = 1;

	localparam logic [PC_W-1:0]  CALLEE_TAG = 32'h1000_0000;
	localparam logic [PC_W-1:0]  SPAN       = PC_W'(BUCKETS) << 2;
	localparam logic [CNT_W-1:0] COUNT_MAX  = {CNT_W{1'b1}};

	localparam logic [CFGI_W-1:0] CFG_WINDOW_BASE = 2'd0;
	localparam logic [CFGI_W-1:0] CFG_WINDOW_SIZE = 2'd1;
	localparam logic [CFGI_W-1:0] CFG_ARC_LIMIT   = 2'd2;
	localparam logic [CFGI_W-1:0] CFG_ENABLE      = 2'd3;

	localparam logic [1:0] CMD_RECORD    = 2'd0;
	localparam logic [1:0] CMD_READ_ARC  = 2'd1;
	localparam logic [1:0] CMD_READ_HEAD = 2'd2;

	typedef enum logic [ST_W-1:0] {
		RES_HEAD_HIT  = 3'd0,
		RES_MOVED     = 3'd1,
		RES_NEW_ARC   = 3'd2,
		RES_OUT_RANGE = 3'd3,
		RES_FULL      = 3'd4,
		RES_IGNORED   = 3'd5,
		RES_READ      = 3'd6
	} res_e;

	typedef enum logic [2:0] {
		OP_REC,
		OP_REC_OOR,
		OP_RD_ARC,
		OP_RD_HEAD,
		OP_FIXED
	} op_e;

	typedef enum logic [2:0] {
		BS_CLEAR,
		BS_IDLE,
		BS_HEAD,
		BS_ENT,
		BS_MOVE,
		BS_ALLOC,
		BS_RDARC,
		BS_RDHEAD
	} bstate_e;

	typedef struct packed {
		op_e                 op;
		res_e                fixed_status;
		logic [BUCKET_W-1:0] bucket;
		logic [PC_W-1:0]     callee;
		logic [RIDX_W-1:0]   index;
	} job_t;

	typedef struct packed {
		res_e              status;
		logic [OUTI_W-1:0] arc_index;
		logic [CNT_W-1:0]  arc_count;
		logic [PC_W-1:0]   arc_callee;
		logic [IDX_W-1:0]  arc_link;
	} res_t;

	typedef struct packed {
		logic [PC_W-1:0]    window_base;
		logic [WSIZE_W-1:0] window_size;
		logic               enable;
	} fcfg_t;

endpackage

>>> hw/rtl/cacnt_ram.sv
// ----------------------------------------------------------------------------
// cacnt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cacnt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hw/rtl/cacnt_fifo.sv
// ----------------------------------------------------------------------------
// cacnt_fifo
// Short job queue between the classifier and the table sequencer.
// ----------------------------------------------------------------------------
module cacnt_fifo import cacnt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t head_job,
	output logic full,
	output logic empty
);

	job_t               slot_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wptr_q;
	logic [Q_PTR_W-1:0] rptr_q;
	logic [Q_PTR_W:0]   count_q;

	assign full     = (count_q == (Q_PTR_W+1)'(Q_DEPTH));
	assign empty    = (count_q == '0);
	assign head_job = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/cacnt_front.sv
// ----------------------------------------------------------------------------
// cacnt_front
// Accepts items, checks the window and read ranges, and queues a job.
// ----------------------------------------------------------------------------
module cacnt_front import cacnt_pkg::*; (
	input  fcfg_t             cfg,
	input  logic              table_ready,
	input  logic              q_full,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        cmd,
	input  logic [PC_W-1:0]   caller_pc,
	input  logic [PC_W-1:0]   callee_pc,
	input  logic [RIDX_W-1:0] read_index,
	output logic              push,
	output job_t              push_job
);

	logic [PC_W-1:0] base;
	logic [PC_W-1:0] offset;
	logic            out_range;

	assign base      = {cfg.window_base[PC_W-1:4], 4'h0};
	assign offset    = caller_pc - base;
	assign out_range = (offset >= PC_W'(cfg.window_size)) || (offset >= SPAN);

	assign in_ready = table_ready && !q_full;
	assign push     = in_valid && in_ready;

	always_comb begin
		push_job              = '0;
		push_job.callee       = callee_pc;
		push_job.index        = read_index;
		push_job.bucket       = offset[BUCKET_W+1:2];
		push_job.fixed_status = RES_IGNORED;
		push_job.op           = OP_FIXED;
		unique case (cmd)
			CMD_RECORD: begin
				if (!cfg.enable) begin
					push_job.op = OP_FIXED;
				end else if (out_range) begin
					push_job.op = OP_REC_OOR;
				end else begin
					push_job.op = OP_REC;
				end
			end
			CMD_READ_ARC: begin
				if ({1'b0, read_index} < (RIDX_W+1)'(ARC_ENTRIES)) begin
					push_job.op = OP_RD_ARC;
				end else begin
					push_job.fixed_status = RES_OUT_RANGE;
				end
			end
			CMD_READ_HEAD: begin
				if ({1'b0, read_index} < (RIDX_W+1)'(BUCKETS)) begin
					push_job.op = OP_RD_HEAD;
				end else begin
					push_job.fixed_status = RES_OUT_RANGE;
				end
			end
			default: begin
				push_job.op = OP_FIXED;
			end
		endcase
	end

endmodule

>>> hw/rtl/cacnt_back.sv
// ----------------------------------------------------------------------------
// cacnt_back
// Table sequencer: walks bucket chains, updates entries, holds the result.
// ----------------------------------------------------------------------------
module cacnt_back import cacnt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [OUTI_W-1:0] arc_limit,
	input  logic              q_empty,
	input  job_t              q_job,
	output logic              pop,
	output logic              table_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output res_t              res
);

	bstate_e             state_q, state_d;
	logic [BUCKET_W-1:0] clr_q;
	job_t                job_q;
	logic [IDX_W-1:0]    head_q;
	logic [IDX_W-1:0]    cur_q;
	logic [IDX_W-1:0]    prev_q;
	logic                first_q;
	logic [LA_W-1:0]     steps_q;
	logic [LA_W-1:0]     last_q;
	logic                halted_q;
	logic                out_valid_q;
	res_t                res_q;

	logic                bk_we;
	logic [BUCKET_W-1:0] bk_waddr, bk_raddr;
	logic [IDX_W-1:0]    bk_wdata, bk_rdata;
	logic [IDX_W-1:0]    arc_raddr;
	logic                ce_we, cn_we, ln_we;
	logic [IDX_W-1:0]    ce_waddr, cn_waddr, ln_waddr;
	logic [CNT_W-1:0]    ce_wdata, cn_wdata;
	logic [IDX_W-1:0]    ln_wdata;
	logic [CNT_W-1:0]    ce_rdata, cn_rdata;
	logic [IDX_W-1:0]    ln_rdata;

	logic                out_free;
	logic                out_load;
	res_t                out_d;
	logic [PC_W-1:0]     tag_callee;
	logic                match;
	logic [CNT_W-1:0]    bumped;
	logic [LA_W-1:0]     la;
	logic [LA_W-1:0]     limit;
	logic                full_now;

	cacnt_ram #(.WIDTH(IDX_W), .DEPTH(BUCKETS)) u_heads (
		.clk(clk), .we(bk_we), .waddr(bk_waddr), .wdata(bk_wdata),
		.raddr(bk_raddr), .rdata(bk_rdata)
	);
	cacnt_ram #(.WIDTH(CNT_W), .DEPTH(ARC_ENTRIES)) u_callee (
		.clk(clk), .we(ce_we), .waddr(ce_waddr), .wdata(ce_wdata),
		.raddr(arc_raddr), .rdata(ce_rdata)
	);
	cacnt_ram #(.WIDTH(CNT_W), .DEPTH(ARC_ENTRIES)) u_count (
		.clk(clk), .we(cn_we), .waddr(cn_waddr), .wdata(cn_wdata),
		.raddr(arc_raddr), .rdata(cn_rdata)
	);
	cacnt_ram #(.WIDTH(IDX_W), .DEPTH(ARC_ENTRIES)) u_link (
		.clk(clk), .we(ln_we), .waddr(ln_waddr), .wdata(ln_wdata),
		.raddr(arc_raddr), .rdata(ln_rdata)
	);

	assign out_free    = !out_valid_q || out_ready;
	assign pop         = (state_q == BS_IDLE) && !q_empty && out_free;
	assign table_ready = (state_q != BS_CLEAR);
	assign out_valid   = out_valid_q;
	assign res         = res_q;

	assign tag_callee = CALLEE_TAG | PC_W'(ce_rdata);
	assign match      = (tag_callee == job_q.callee);
	assign bumped     = (cn_rdata == COUNT_MAX) ? COUNT_MAX : cn_rdata + 1'b1;
	assign la         = last_q + 1'b1;
	assign limit      = (LA_W'(arc_limit) < LA_W'(ARC_ENTRIES)) ? LA_W'(arc_limit)
	                                                             : LA_W'(ARC_ENTRIES);
	assign full_now   = (la >= limit);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BS_CLEAR: begin
				if (clr_q == BUCKET_W'(BUCKETS - 1)) begin
					state_d = BS_IDLE;
				end
			end
			BS_IDLE: begin
				if (pop) begin
					unique case (q_job.op)
						OP_REC:     state_d = halted_q ? BS_IDLE : BS_HEAD;
						OP_RD_ARC:  state_d = BS_RDARC;
						OP_RD_HEAD: state_d = BS_RDHEAD;
						default:    state_d = BS_IDLE;
					endcase
				end
			end
			BS_HEAD: begin
				state_d = (bk_rdata != '0) ? BS_ENT : BS_ALLOC;
			end
			BS_ENT: begin
				if (match) begin
					state_d = first_q ? BS_IDLE : BS_MOVE;
				end else if (ln_rdata == '0 || steps_q == LA_W'(ARC_ENTRIES)) begin
					state_d = BS_ALLOC;
				end
			end
			BS_MOVE, BS_ALLOC, BS_RDARC, BS_RDHEAD: begin
				state_d = BS_IDLE;
			end
			default: begin
				state_d = BS_IDLE;
			end
		endcase
	end

	always_comb begin
		bk_we     = 1'b0;
		bk_waddr  = job_q.bucket;
		bk_wdata  = '0;
		bk_raddr  = q_job.bucket;
		arc_raddr = bk_rdata;
		ce_we     = 1'b0;
		ce_waddr  = la[IDX_W-1:0];
		ce_wdata  = job_q.callee[CNT_W-1:0];
		cn_we     = 1'b0;
		cn_waddr  = cur_q;
		cn_wdata  = bumped;
		ln_we     = 1'b0;
		ln_waddr  = prev_q;
		ln_wdata  = ln_rdata;
		out_load  = 1'b0;
		out_d     = '0;
		out_d.status = RES_READ;
		unique case (state_q)
			BS_CLEAR: begin
				bk_we    = 1'b1;
				bk_waddr = clr_q;
			end
			BS_IDLE: begin
				if (q_job.op == OP_RD_HEAD) begin
					bk_raddr = BUCKET_W'(q_job.index);
				end
				arc_raddr = IDX_W'(q_job.index);
				if (pop) begin
					unique case (q_job.op)
						OP_REC: begin
							out_load     = halted_q;
							out_d.status = RES_IGNORED;
						end
						OP_REC_OOR: begin
							out_load     = 1'b1;
							out_d.status = halted_q ? RES_IGNORED : RES_OUT_RANGE;
						end
						OP_FIXED: begin
							out_load     = 1'b1;
							out_d.status = q_job.fixed_status;
						end
						default: begin
							out_load = 1'b0;
						end
					endcase
				end
			end
			BS_HEAD: begin
				arc_raddr = bk_rdata;
			end
			BS_ENT: begin
				arc_raddr = ln_rdata;
				if (match) begin
					cn_we            = 1'b1;
					out_load         = 1'b1;
					out_d.arc_index  = OUTI_W'(cur_q);
					out_d.arc_count  = bumped;
					out_d.arc_callee = tag_callee;
					if (first_q) begin
						out_d.status   = RES_HEAD_HIT;
						out_d.arc_link = ln_rdata;
					end else begin
						// Unlink from the predecessor and make it the new head.
						out_d.status   = RES_MOVED;
						out_d.arc_link = head_q;
						ln_we          = 1'b1;
						bk_we          = 1'b1;
						bk_wdata       = cur_q;
					end
				end
			end
			BS_MOVE: begin
				ln_we    = 1'b1;
				ln_waddr = cur_q;
				ln_wdata = head_q;
			end
			BS_ALLOC: begin
				out_load        = 1'b1;
				out_d.arc_index = OUTI_W'(la);
				if (full_now) begin
					out_d.status = RES_FULL;
				end else begin
					ce_we            = 1'b1;
					cn_we            = 1'b1;
					cn_waddr         = la[IDX_W-1:0];
					cn_wdata         = CNT_W'(1);
					ln_we            = 1'b1;
					ln_waddr         = la[IDX_W-1:0];
					ln_wdata         = head_q;
					bk_we            = 1'b1;
					bk_wdata         = la[IDX_W-1:0];
					out_d.status     = RES_NEW_ARC;
					out_d.arc_count  = CNT_W'(1);
					out_d.arc_callee = CALLEE_TAG | PC_W'(job_q.callee[CNT_W-1:0]);
					out_d.arc_link   = head_q;
				end
			end
			BS_RDARC: begin
				out_load         = 1'b1;
				out_d.arc_index  = OUTI_W'(job_q.index);
				out_d.arc_count  = cn_rdata;
				out_d.arc_callee = tag_callee;
				out_d.arc_link   = ln_rdata;
			end
			BS_RDHEAD: begin
				out_load        = 1'b1;
				out_d.arc_index = OUTI_W'(bk_rdata);
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= q_job;
		end
		if (out_load) begin
			res_q <= out_d;
		end
		if (state_q == BS_HEAD) begin
			head_q  <= bk_rdata;
			cur_q   <= bk_rdata;
			first_q <= 1'b1;
			steps_q <= '0;
		end else if (state_q == BS_ENT && !match) begin
			prev_q  <= cur_q;
			cur_q   <= ln_rdata;
			first_q <= 1'b0;
			steps_q <= steps_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BS_CLEAR;
			clr_q       <= '0;
			last_q      <= '0;
			halted_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BS_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == BS_ALLOC) begin
				last_q <= la;
				if (full_now) begin
					halted_q <= 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halted flag cleared without reset");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == BS_IDLE) && out_free)
		else $error("job taken while sequencer busy");

	a_no_load_over: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("result overwrote an undelivered result");

	a_alloc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(last_q <= LA_W'(ARC_ENTRIES)))
		else $error("allocation index beyond table");

endmodule

>>> hw/rtl/call_arc_count_table_core.sv
// ----------------------------------------------------------------------------
// call_arc_count_table_core
// Call-graph arc recorder with bucket chains and move-to-front on hits.
//
//  channel  signals                                     direction
//  cfg      cfg_we, cfg_index, cfg_wdata                in, write only
//  in       in_valid/in_ready, cmd, caller_pc,          in
//           callee_pc, read_index
//  out      out_valid/out_ready, status, arc_index,     out
//           arc_count, arc_callee, arc_link
//
// A read passes through one read state; an out-of-range record is answered
// from idle, and a record reads the bucket head, then one chain link per step.
// After reset a clearing pass zeroes the 4096 bucket heads, one per cycle,
// before in_ready rises. A two-entry job queue lets the classifier take
// items while the sequencer works or waits on out_ready.
// ----------------------------------------------------------------------------
module call_arc_count_table_core import cacnt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFGI_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        cmd,
	input  logic [PC_W-1:0]   caller_pc,
	input  logic [PC_W-1:0]   callee_pc,
	input  logic [RIDX_W-1:0] read_index,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ST_W-1:0]   status,
	output logic [OUTI_W-1:0] arc_index,
	output logic [CNT_W-1:0]  arc_count,
	output logic [PC_W-1:0]   arc_callee,
	output logic [IDX_W-1:0]  arc_link
);

	fcfg_t             fcfg_q;
	logic [OUTI_W-1:0] arc_limit_q;
	logic              table_ready;
	logic              q_full, q_empty, push, pop;
	job_t              push_job, q_job;
	res_t              res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcfg_q.window_base <= 32'h1000_0000;
			fcfg_q.window_size <= WSIZE_W'(16384);
			fcfg_q.enable      <= 1'b0;
			arc_limit_q        <= OUTI_W'(1024);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WINDOW_BASE: fcfg_q.window_base <= cfg_wdata;
				CFG_WINDOW_SIZE: fcfg_q.window_size <= cfg_wdata[WSIZE_W-1:0];
				CFG_ARC_LIMIT:   arc_limit_q        <= cfg_wdata[OUTI_W-1:0];
				CFG_ENABLE:      fcfg_q.enable      <= cfg_wdata[0];
				default:         arc_limit_q        <= arc_limit_q;
			endcase
		end
	end

	cacnt_front u_front (
		.cfg(fcfg_q), .table_ready(table_ready), .q_full(q_full),
		.in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
		.caller_pc(caller_pc), .callee_pc(callee_pc), .read_index(read_index),
		.push(push), .push_job(push_job)
	);

	cacnt_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .push_job(push_job),
		.pop(pop), .head_job(q_job), .full(q_full), .empty(q_empty)
	);

	cacnt_back u_back (
		.clk(clk), .arst_n(arst_n), .arc_limit(arc_limit_q),
		.q_empty(q_empty), .q_job(q_job), .pop(pop), .table_ready(table_ready),
		.out_valid(out_valid), .out_ready(out_ready), .res(res)
	);

	assign status     = res.status;
	assign arc_index  = res.arc_index;
	assign arc_count  = res.arc_count;
	assign arc_callee = res.arc_callee;
	assign arc_link   = res.arc_link;

endmodule
